### hdl/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

    // Coordinate width of the inputs; at most 32 bits carry information.
    localparam int COORD_WIDTH = 32;
    localparam int FW = 32;
    localparam int CW = (COORD_WIDTH > FW) ? FW : COORD_WIDTH;
    localparam int RAD_W = 31;

    // Dot products of three magnitude products, each below 2^(2*CW).
    localparam int PROD_W = 2 * CW;
    localparam int DOT_W = PROD_W + 2;

    // Contact offset division: dividend and quotient widths.
    localparam int CN_W = CW + DOT_W;
    localparam int CQ_W = CW;

    // Length: the squared distance is scaled by 2^56 before the root.
    localparam int SQ_SHIFT = 56;
    localparam int R_W = (DOT_W + SQ_SHIFT + 1) / 2;
    localparam int X_W = 2 * R_W;

    // Distance rounding from the scaled root back to Q16.16.
    localparam int DIST_SHIFT = 28;
    localparam int DIST_W = R_W - DIST_SHIFT + 1;
    localparam int DEP_W = ((DIST_W > RAD_W) ? DIST_W : RAD_W) + 2;

    // Normal division: |v| * 2^58 plus half the scaled length over that length,
    // result at most 2^30. The rounding term can carry past bit 89.
    localparam int NRM_SHIFT = 58;
    localparam int NN_W = CW + NRM_SHIFT + 1;
    localparam int NQ_W = 31;
    localparam logic [NQ_W-1:0] ONE_Q30 = NQ_W'(1) << 30;

    typedef struct packed {
        logic [2:0][FW-1:0] p0;
        logic [2:0][FW-1:0] p1;
        logic [2:0][FW-1:0] c;
        logic [RAD_W-1:0]   radius;
    } t_in;

    // Contact point and center offset after the projection.
    typedef struct packed {
        logic [2:0][CW-1:0] pt;
        logic [2:0][CW:0]   v;
        logic [RAD_W-1:0]   radius;
    } t_pv;

    // Scaled length together with the projection data.
    typedef struct packed {
        logic [R_W-1:0] len;
        t_pv            pv;
    } t_sq;

    typedef struct packed {
        logic               hit;
        logic [2:0][FW-1:0] contact;
        logic [FW-1:0]      penetration;
        logic [2:0][FW-1:0] normal;
    } t_result;

    // Magnitude of a signed difference of two coordinates.
    function automatic logic [CW-1:0] mag_of(input logic [CW:0] x);
        logic [CW:0] t;
        t = x[CW] ? (~x + 1'b1) : x;
        return t[CW-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/ssc_if.sv
`default_nettype none

// Request channel: one segment and one sphere per request.
interface ssc_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
    logic signed [31:0] ball_center_x;
    logic signed [31:0] ball_center_y;
    logic signed [31:0] ball_center_z;
    logic [30:0]        ball_radius;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
               seg_end_z, ball_center_x, ball_center_y, ball_center_z, ball_radius,
        input  ready
    );
    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
               seg_end_z, ball_center_x, ball_center_y, ball_center_z, ball_radius,
        output ready
    );
endinterface

// Response channel: one contact result per request.
interface ssc_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
    logic signed [31:0] penetration;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;

    modport source (
        output valid, hit, contact_x, contact_y, contact_z, penetration,
               normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, hit, contact_x, contact_y, contact_z, penetration,
               normal_x, normal_y, normal_z,
        output ready
    );
endinterface

`default_nettype wire

### hdl/ssc_proj.sv
`default_nettype none

module ssc_proj (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire ssc_pkg::t_in  i_item,
    output logic               o_valid,
    output ssc_pkg::t_pv       o_data
);

    localparam int CW = ssc_pkg::CW;
    localparam int DOT_W = ssc_pkg::DOT_W;
    localparam int PROD_W = ssc_pkg::PROD_W;
    localparam int CN_W = ssc_pkg::CN_W;
    localparam int CQ_W = ssc_pkg::CQ_W;

    typedef enum logic [1:0] {MODE_START, MODE_END, MODE_MID} t_mode;

    typedef struct packed {
        logic [2:0][CW-1:0]          p0;
        logic [2:0][CW-1:0]          p1;
        logic [2:0][CW-1:0]          c;
        logic [2:0][CW-1:0]          md;
        logic [2:0]                  dneg;
        logic [ssc_pkg::RAD_W-1:0]   radius;
    } t_side;

    // Stage 1: segment direction and center offset, as magnitudes and signs.
    logic [2:0][CW:0] d_diff, q_diff;
    logic             r_v1;
    t_side            r_s1;
    logic [2:0][CW-1:0] r_mq1;
    logic [2:0]       r_ng1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_diff[i] = {i_item.p1[i][CW-1], i_item.p1[i][CW-1:0]}
                      - {i_item.p0[i][CW-1], i_item.p0[i][CW-1:0]};
            q_diff[i] = {i_item.c[i][CW-1], i_item.c[i][CW-1:0]}
                      - {i_item.p0[i][CW-1], i_item.p0[i][CW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1.p0[i]   <= i_item.p0[i][CW-1:0];
                r_s1.p1[i]   <= i_item.p1[i][CW-1:0];
                r_s1.c[i]    <= i_item.c[i][CW-1:0];
                r_s1.md[i]   <= ssc_pkg::mag_of(d_diff[i]);
                r_s1.dneg[i] <= d_diff[i][CW];
                r_mq1[i]     <= ssc_pkg::mag_of(q_diff[i]);
                r_ng1[i]     <= q_diff[i][CW] ^ d_diff[i][CW];
            end
            r_s1.radius <= i_item.radius;
        end
    end

    // Stage 2: per-axis products for the two dot products.
    logic                   r_v2;
    t_side                  r_s2;
    logic [2:0][PROD_W-1:0] r_pr2, r_dd2;
    logic [2:0]             r_ng2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pr2[i] <= r_mq1[i] * r_s1.md[i];
                r_dd2[i] <= r_s1.md[i] * r_s1.md[i];
            end
            r_ng2 <= r_ng1;
            r_s2  <= r_s1;
        end
    end

    // Stage 3: positive and negative parts of the projection, and the length squared.
    logic [DOT_W-1:0] pos_sum, neg_sum, den_sum;
    logic             r_v3;
    t_side            r_s3;
    logic [DOT_W-1:0] r_pos3, r_neg3, r_den3;

    always_comb begin
        pos_sum = '0;
        neg_sum = '0;
        den_sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_ng2[i]) begin
                neg_sum = neg_sum + DOT_W'(r_pr2[i]);
            end else begin
                pos_sum = pos_sum + DOT_W'(r_pr2[i]);
            end
            den_sum = den_sum + DOT_W'(r_dd2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos3 <= pos_sum;
            r_neg3 <= neg_sum;
            r_den3 <= den_sum;
            r_s3   <= r_s2;
        end
    end

    // Stage 4: clamp the parameter to the start, the end or the interior.
    logic [DOT_W-1:0] num_w;
    logic             r_v4;
    t_side            r_s4;
    logic [DOT_W-1:0] r_num4, r_den4;
    t_mode            r_mode4;

    assign num_w = r_pos3 - r_neg3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if ((r_neg3 >= r_pos3) || (r_den3 == '0)) begin
                r_mode4 <= MODE_START;
            end else if (num_w >= r_den3) begin
                r_mode4 <= MODE_END;
            end else begin
                r_mode4 <= MODE_MID;
            end
            r_num4 <= num_w;
            r_den4 <= r_den3;
            r_s4   <= r_s3;
        end
    end

    // Stage 5: direction magnitude times the projection, in two partial products.
    logic                        r_v5;
    t_side                       r_s5;
    logic [DOT_W-1:0]            r_den5;
    t_mode                       r_mode5;
    logic [2:0][PROD_W-1:0]      r_plo5;
    logic [2:0][DOT_W-1:0]       r_phi5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_plo5[i] <= r_s4.md[i] * r_num4[CW-1:0];
                r_phi5[i] <= r_s4.md[i] * r_num4[DOT_W-1:CW];
            end
            r_den5  <= r_den4;
            r_mode5 <= r_mode4;
            r_s5    <= r_s4;
        end
    end

    // Stage 6 and the divider: one quotient bit of each offset per stage.
    logic [DOT_W-1:0] r_rem [0:CQ_W][0:2];
    logic [CQ_W-1:0]  r_lo  [0:CQ_W][0:2];
    logic [DOT_W-1:0] r_dv  [0:CQ_W];
    t_side            r_sd  [0:CQ_W];
    t_mode            r_mo  [0:CQ_W];
    logic             r_vd  [0:CQ_W];

    for (genvar i = 0; i < 3; i++) begin : g_dividend
        logic [CN_W-1:0] dvd;
        assign dvd = (CN_W'(r_phi5[i]) << CW) + CN_W'(r_plo5[i]) + CN_W'(r_den5 >> 1);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][i] <= dvd[CN_W-1:CQ_W];
                r_lo[0][i]  <= dvd[CQ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (i_en) begin
            r_vd[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= r_den5;
            r_sd[0] <= r_s5;
            r_mo[0] <= r_mode5;
        end
    end

    for (genvar k = 0; k < CQ_W; k++) begin : g_div
        for (genvar i = 0; i < 3; i++) begin : g_axis
            logic [DOT_W:0] sh, df;
            assign sh = {r_rem[k][i], r_lo[k][i][CQ_W-1]};
            assign df = sh - {1'b0, r_dv[k]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1][i] <= df[DOT_W] ? sh[DOT_W-1:0] : df[DOT_W-1:0];
                    r_lo[k+1][i]  <= {r_lo[k][i][CQ_W-2:0], ~df[DOT_W]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vd[k+1] <= r_vd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k+1] <= r_dv[k];
                r_sd[k+1] <= r_sd[k];
                r_mo[k+1] <= r_mo[k];
            end
        end
    end

    // Last stage: contact point and its offset from the center.
    logic [2:0][CW:0]   mid_pt, v_w;
    logic [2:0][CW-1:0] sel_pt;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_sd[CQ_W].dneg[i]) begin
                mid_pt[i] = {r_sd[CQ_W].p0[i][CW-1], r_sd[CQ_W].p0[i]}
                          - {1'b0, r_lo[CQ_W][i]};
            end else begin
                mid_pt[i] = {r_sd[CQ_W].p0[i][CW-1], r_sd[CQ_W].p0[i]}
                          + {1'b0, r_lo[CQ_W][i]};
            end
            unique case (r_mo[CQ_W])
                MODE_END: sel_pt[i] = r_sd[CQ_W].p1[i];
                MODE_MID: sel_pt[i] = mid_pt[i][CW-1:0];
                default:  sel_pt[i] = r_sd[CQ_W].p0[i];
            endcase
            v_w[i] = {sel_pt[i][CW-1], sel_pt[i]}
                   - {r_sd[CQ_W].c[i][CW-1], r_sd[CQ_W].c[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vd[CQ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data.pt     <= sel_pt;
            o_data.v      <= v_w;
            o_data.radius <= r_sd[CQ_W].radius;
        end
    end

endmodule

`default_nettype wire

### hdl/ssc_sqrt.sv
`default_nettype none

module ssc_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire ssc_pkg::t_pv  i_data,
    output logic               o_valid,
    output ssc_pkg::t_sq       o_data
);

    localparam int CW = ssc_pkg::CW;
    localparam int DOT_W = ssc_pkg::DOT_W;
    localparam int PROD_W = ssc_pkg::PROD_W;
    localparam int R_W = ssc_pkg::R_W;
    localparam int X_W = ssc_pkg::X_W;

    // Stage A: squares of the offset components.
    logic [2:0][CW-1:0]     v_mag;
    logic                   r_va;
    ssc_pkg::t_pv           r_pva;
    logic [2:0][PROD_W-1:0] r_sqa;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_mag[i] = ssc_pkg::mag_of(i_data.v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sqa[i] <= v_mag[i] * v_mag[i];
            end
            r_pva <= i_data;
        end
    end

    // Stage B: squared distance, scaled, loaded into the root pipeline.
    logic [DOT_W-1:0] sq_sum;
    logic [X_W-1:0]   r_x  [0:R_W];
    logic [R_W:0]     r_rm [0:R_W];
    logic [R_W-1:0]   r_rt [0:R_W];
    ssc_pkg::t_pv     r_pv [0:R_W];
    logic             r_vq [0:R_W];

    assign sq_sum = DOT_W'(r_sqa[0]) + DOT_W'(r_sqa[1]) + DOT_W'(r_sqa[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq[0] <= 1'b0;
        end else if (i_en) begin
            r_vq[0] <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= X_W'(sq_sum) << ssc_pkg::SQ_SHIFT;
            r_rm[0] <= '0;
            r_rt[0] <= '0;
            r_pv[0] <= r_pva;
        end
    end

    // Digit-by-digit root: one result bit per stage.
    for (genvar k = 0; k < R_W; k++) begin : g_root
        logic [R_W+2:0] rem2, trial, df;
        logic           ge;

        assign rem2  = {r_rm[k], r_x[k][X_W-1 -: 2]};
        assign trial = {1'b0, r_rt[k], 2'b01};
        assign ge    = rem2 >= trial;
        assign df    = rem2 - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vq[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vq[k+1] <= r_vq[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rm[k+1] <= ge ? df[R_W:0] : rem2[R_W:0];
                r_rt[k+1] <= {r_rt[k][R_W-2:0], ge};
                r_x[k+1]  <= {r_x[k][X_W-3:0], 2'b00};
                r_pv[k+1] <= r_pv[k];
            end
        end
    end

    assign o_valid     = r_vq[R_W];
    assign o_data.len  = r_rt[R_W];
    assign o_data.pv   = r_pv[R_W];

endmodule

`default_nettype wire

### hdl/ssc_norm.sv
`default_nettype none

module ssc_norm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire ssc_pkg::t_sq    i_data,
    output logic                 o_valid,
    output ssc_pkg::t_result     o_res
);

    localparam int CW = ssc_pkg::CW;
    localparam int FW = ssc_pkg::FW;
    localparam int R_W = ssc_pkg::R_W;
    localparam int NN_W = ssc_pkg::NN_W;
    localparam int NQ_W = ssc_pkg::NQ_W;
    localparam int DEP_W = ssc_pkg::DEP_W;
    localparam int DIST_W = ssc_pkg::DIST_W;
    localparam int DIST_SHIFT = ssc_pkg::DIST_SHIFT;

    typedef struct packed {
        logic               hit;
        logic [FW-1:0]      pen;
        logic [2:0][CW-1:0] pt;
        logic [2:0]         vneg;
        logic               lz;
    } t_nside;

    // Entry stage: rounded distance, penetration with saturation, dividends.
    logic [R_W:0]       len_rnd;
    logic [DIST_W-1:0]  dist_rnd;
    logic [DEP_W-1:0]   depth;
    logic               sat;
    t_nside             side0;

    assign len_rnd  = {1'b0, i_data.len} + ((R_W + 1)'(1) << (DIST_SHIFT - 1));
    assign dist_rnd = len_rnd[R_W:DIST_SHIFT];
    assign depth    = DEP_W'(i_data.pv.radius) - DEP_W'(dist_rnd);
    assign sat      = depth[DEP_W-1] && !(&depth[DEP_W-1:FW-1]);

    always_comb begin
        side0.hit = ~depth[DEP_W-1];
        side0.pen = sat ? {1'b1, {(FW - 1){1'b0}}} : depth[FW-1:0];
        side0.pt  = i_data.pv.pt;
        for (int i = 0; i < 3; i++) begin
            side0.vneg[i] = i_data.pv.v[i][CW];
        end
        side0.lz = (i_data.len == '0);
    end

    logic [R_W-1:0]  r_rem [0:NQ_W][0:2];
    logic [NQ_W-1:0] r_lo  [0:NQ_W][0:2];
    logic [R_W-1:0]  r_ln  [0:NQ_W];
    t_nside          r_sd  [0:NQ_W];
    logic            r_vd  [0:NQ_W];

    for (genvar i = 0; i < 3; i++) begin : g_dividend
        logic [NN_W-1:0] dvd;
        assign dvd = (NN_W'(ssc_pkg::mag_of(i_data.pv.v[i])) << ssc_pkg::NRM_SHIFT)
                   + NN_W'(i_data.len >> 1);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][i] <= R_W'(dvd >> NQ_W);
                r_lo[0][i]  <= dvd[NQ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (i_en) begin
            r_vd[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ln[0] <= i_data.len;
            r_sd[0] <= side0;
        end
    end

    // Divider: one quotient bit of each normal component per stage.
    for (genvar k = 0; k < NQ_W; k++) begin : g_div
        for (genvar i = 0; i < 3; i++) begin : g_axis
            logic [R_W:0] sh, df;
            assign sh = {r_rem[k][i], r_lo[k][i][NQ_W-1]};
            assign df = sh - {1'b0, r_ln[k]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1][i] <= df[R_W] ? sh[R_W-1:0] : df[R_W-1:0];
                    r_lo[k+1][i]  <= {r_lo[k][i][NQ_W-2:0], ~df[R_W]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vd[k+1] <= r_vd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ln[k+1] <= r_ln[k];
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    // Output stage: clamp, apply signs, and handle a point on the center.
    logic [2:0][NQ_W-1:0] q_clamp;
    logic [2:0][FW-1:0]   nrm;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_clamp[i] = (r_lo[NQ_W][i] > ssc_pkg::ONE_Q30) ? ssc_pkg::ONE_Q30
                                                              : r_lo[NQ_W][i];
            nrm[i] = r_sd[NQ_W].vneg[i] ? (~FW'(q_clamp[i]) + 1'b1) : FW'(q_clamp[i]);
        end
        if (r_sd[NQ_W].lz) begin
            nrm[0] = FW'(ssc_pkg::ONE_Q30);
            nrm[1] = '0;
            nrm[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vd[NQ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.hit         <= r_sd[NQ_W].hit;
            o_res.penetration <= r_sd[NQ_W].pen;
            o_res.normal      <= nrm;
            for (int i = 0; i < 3; i++) begin
                o_res.contact[i] <= FW'($signed(r_sd[NQ_W].pt[i]));
            end
        end
    end

endmodule

`default_nettype wire

### hdl/segment_sphere_contact_core.sv
`default_nettype none

// Segment against sphere contact query.
// i_req carries one segment (start and end) and one sphere (center, radius) per
// request, signed Q16.16. o_rsp returns one result per request, in order: the
// closest point on the segment, the penetration depth (radius minus distance,
// saturated), the hit flag (depth not negative) and the unit normal in Q1.30
// from the center toward the point, (1,0,0) when the point sits on the center.
// Throughput is one request per cycle while the output buffer has room. Each
// request passes through 136 register stages: 39 for the projection and its
// 32-bit offset divider, 63 for the length squared and its bit-per-stage
// square root, 33 for the 31-bit normal divider and output formatting, and
// one into the two-entry output buffer.
// When the receiver stalls, the buffer absorbs results until it is full; the
// whole pipeline then holds and i_req.ready drops, so no request is lost or
// repeated. A synchronous active-low reset empties the pipeline and the buffer;
// there is no configuration.
module segment_sphere_contact_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssc_req_if.sink   i_req,
    ssc_rsp_if.source o_rsp
);

    localparam logic [1:0] BUF_FULL = 2'd2;

    logic               pipe_en;
    ssc_pkg::t_in       req_item;
    logic               proj_valid, sqrt_valid, norm_valid;
    ssc_pkg::t_pv       proj_data;
    ssc_pkg::t_sq       sqrt_data;
    ssc_pkg::t_result   norm_res;
    logic               push, pop;

    ssc_pkg::t_result   r_buf [0:1];
    logic               r_wptr, r_rptr;
    logic [1:0]         r_cnt;

    // The pipeline advances while the output buffer has room.
    assign pipe_en     = (r_cnt != BUF_FULL);
    assign i_req.ready = pipe_en;

    always_comb begin
        req_item.p0[0] = i_req.seg_start_x;
        req_item.p0[1] = i_req.seg_start_y;
        req_item.p0[2] = i_req.seg_start_z;
        req_item.p1[0] = i_req.seg_end_x;
        req_item.p1[1] = i_req.seg_end_y;
        req_item.p1[2] = i_req.seg_end_z;
        req_item.c[0]  = i_req.ball_center_x;
        req_item.c[1]  = i_req.ball_center_y;
        req_item.c[2]  = i_req.ball_center_z;
        req_item.radius = i_req.ball_radius;
    end

    ssc_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_req.valid),
        .i_item  (req_item),
        .o_valid (proj_valid),
        .o_data  (proj_data)
    );

    ssc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (proj_valid),
        .i_data  (proj_data),
        .o_valid (sqrt_valid),
        .o_data  (sqrt_data)
    );

    ssc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (sqrt_valid),
        .i_data  (sqrt_data),
        .o_valid (norm_valid),
        .o_res   (norm_res)
    );

    // Two-entry output buffer between the pipeline and the receiver.
    assign push = pipe_en && norm_valid;
    assign pop  = o_rsp.valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= norm_res;
        end
    end

    assign o_rsp.valid       = (r_cnt != 2'd0);
    assign o_rsp.hit         = r_buf[r_rptr].hit;
    assign o_rsp.contact_x   = r_buf[r_rptr].contact[0];
    assign o_rsp.contact_y   = r_buf[r_rptr].contact[1];
    assign o_rsp.contact_z   = r_buf[r_rptr].contact[2];
    assign o_rsp.penetration = r_buf[r_rptr].penetration;
    assign o_rsp.normal_x    = r_buf[r_rptr].normal[0];
    assign o_rsp.normal_y    = r_buf[r_rptr].normal[1];
    assign o_rsp.normal_z    = r_buf[r_rptr].normal[2];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= BUF_FULL)
        else $error("output buffer count out of range");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == BUF_FULL) |-> !i_req.ready)
        else $error("request taken while output buffer full");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("result pushed without count increment");

    a_empty_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop)
        else $error("response taken from empty buffer");
`endif

endmodule

`default_nettype wire

### sim/segment_sphere_contact_core_tb.sv
`timescale 1ns / 100ps

module segment_sphere_contact_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;

    ssc_req_if req_ch ();
    ssc_rsp_if rsp_ch ();

    segment_sphere_contact_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Expected contact results, oldest first.
    ssc_pkg::t_result contact_fifo[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      quiet_mode = 0;
    int      rsp_hold_cycles = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("segment_sphere_contact_core test failed");
            $finish;
        end
    end

    function automatic logic [63:0] umag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Integer square root of a 128-bit value, bit by bit.
    function automatic logic [63:0] root128(input logic [127:0] x);
        logic [127:0] res;
        logic [127:0] bt;
        res = '0;
        bt = 128'd1 << 126;
        while (bt != 0 && bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res[63:0];
    endfunction

    // Closest point, penetration and normal for one query.
    function automatic ssc_pkg::t_result predict_contact(input ssc_pkg::t_in q);
        longint       p0[3], p1[3], c[3], d[3], pt[3], v[3];
        longint       dq, dist_rnd, depth;
        logic [127:0] pos, neg, num, den, sq, off, nrm;
        logic [63:0]  len;
        ssc_pkg::t_result r;
        pos = '0; neg = '0; den = '0; sq = '0;
        for (int i = 0; i < 3; i++) begin
            p0[i] = longint'($signed(q.p0[2-i]));
            p1[i] = longint'($signed(q.p1[2-i]));
            c[i]  = longint'($signed(q.c[2-i]));
            d[i]  = p1[i] - p0[i];
            dq    = c[i] - p0[i];
            if ((dq < 0) != (d[i] < 0))
                neg = neg + 128'(umag(dq)) * 128'(umag(d[i]));
            else
                pos = pos + 128'(umag(dq)) * 128'(umag(d[i]));
            den = den + 128'(umag(d[i])) * 128'(umag(d[i]));
        end
        // Clamp the projection to the segment, rounding half away from zero.
        if (neg >= pos || den == 0) begin
            for (int i = 0; i < 3; i++) pt[i] = p0[i];
        end else begin
            num = pos - neg;
            for (int i = 0; i < 3; i++) begin
                if (num >= den) begin
                    pt[i] = p1[i];
                end else begin
                    off = (128'(umag(d[i])) * num + (den >> 1)) / den;
                    pt[i] = (d[i] < 0) ? p0[i] - longint'(off[63:0])
                                       : p0[i] + longint'(off[63:0]);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            v[i] = pt[i] - c[i];
            sq = sq + 128'(umag(v[i])) * 128'(umag(v[i]));
        end
        len = root128(sq << 56);
        dist_rnd = longint'((len + (64'd1 << 27)) >> 28);
        depth = longint'(q.radius) - dist_rnd;
        if (depth < -longint'(64'h8000_0000)) depth = -longint'(64'h8000_0000);
        r.hit = (depth >= 0);
        for (int i = 0; i < 3; i++) r.contact[2-i] = pt[i][31:0];
        r.penetration = depth[31:0];
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                r.normal[2-i] = (i == 0) ? 32'h4000_0000 : 32'h0;
            end else begin
                nrm = ((128'(umag(v[i])) << 58) + 128'(len >> 1)) / 128'(len);
                if (nrm > 128'h4000_0000) nrm = 128'h4000_0000;
                r.normal[2-i] = (v[i] < 0) ? -nrm[31:0] : nrm[31:0];
            end
        end
        return r;
    endfunction

    // Send one request and record its expected result on acceptance.
    task automatic send_query(input ssc_pkg::t_in q);
        int gap;
        @(negedge i_clk);
        gap = quiet_mode ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.seg_start_x   <= q.p0[2];
        req_ch.seg_start_y   <= q.p0[1];
        req_ch.seg_start_z   <= q.p0[0];
        req_ch.seg_end_x     <= q.p1[2];
        req_ch.seg_end_y     <= q.p1[1];
        req_ch.seg_end_z     <= q.p1[0];
        req_ch.ball_center_x <= q.c[2];
        req_ch.ball_center_y <= q.c[1];
        req_ch.ball_center_z <= q.c[0];
        req_ch.ball_radius   <= q.radius;
        req_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        contact_fifo.push_back(predict_contact(q));
    endtask

    task automatic release_valid();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (contact_fifo.size() != 0) @(posedge i_clk);
    endtask

    function automatic ssc_pkg::t_in make_query(input logic [2:0][31:0] a,
                                                input logic [2:0][31:0] b,
                                                input logic [2:0][31:0] cc,
                                                input logic [30:0] rad);
        ssc_pkg::t_in q;
        q.p0 = a; q.p1 = b; q.c = cc; q.radius = rad;
        return q;
    endfunction

    function automatic logic [31:0] small_coord();
        return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endfunction

    // Random query drawn from several shapes of geometry.
    function automatic ssc_pkg::t_in random_query();
        ssc_pkg::t_in q;
        int  shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            if (shape < 2) begin
                q.p0[i] = $urandom; q.p1[i] = $urandom; q.c[i] = $urandom;
            end else begin
                q.p0[i] = small_coord(); q.p1[i] = small_coord(); q.c[i] = small_coord();
            end
        end
        if (shape == 2) q.p1 = q.p0;
        if (shape == 3) q.c = q.p0;
        if (shape == 4)
            for (int i = 0; i < 3; i++)
                q.c[i] = 32'(($signed(q.p0[i]) + $signed(q.p1[i])) / 2) + small_coord() / 8;
        if (shape == 5) q.radius = 31'($urandom);
        else q.radius = 31'($urandom_range(0, 1 << 23));
        if (shape == 6) q.radius = '0;
        return q;
    endfunction

    // Response side: random or long stalls, compare each accepted result.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        ssc_pkg::t_result e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (contact_fifo.size() == 0) begin
                $error("unexpected result with nothing outstanding");
                mismatch_count++;
            end else begin
                e = contact_fifo.pop_front();
                if (rsp_ch.hit !== e.hit) begin
                    $error("hit: expected %0d actual %0d", e.hit, rsp_ch.hit);
                    mismatch_count++;
                end
                if (rsp_ch.contact_x !== e.contact[2]) begin
                    $error("contact_x: expected %h actual %h", e.contact[2], rsp_ch.contact_x);
                    mismatch_count++;
                end
                if (rsp_ch.contact_y !== e.contact[1]) begin
                    $error("contact_y: expected %h actual %h", e.contact[1], rsp_ch.contact_y);
                    mismatch_count++;
                end
                if (rsp_ch.contact_z !== e.contact[0]) begin
                    $error("contact_z: expected %h actual %h", e.contact[0], rsp_ch.contact_z);
                    mismatch_count++;
                end
                if (rsp_ch.penetration !== e.penetration) begin
                    $error("penetration: expected %h actual %h", e.penetration,
                           rsp_ch.penetration);
                    mismatch_count++;
                end
                if (rsp_ch.normal_x !== e.normal[2]) begin
                    $error("normal_x: expected %h actual %h", e.normal[2], rsp_ch.normal_x);
                    mismatch_count++;
                end
                if (rsp_ch.normal_y !== e.normal[1]) begin
                    $error("normal_y: expected %h actual %h", e.normal[1], rsp_ch.normal_y);
                    mismatch_count++;
                end
                if (rsp_ch.normal_z !== e.normal[0]) begin
                    $error("normal_z: expected %h actual %h", e.normal[0], rsp_ch.normal_z);
                    mismatch_count++;
                end
            end
        end
    end

    // Corner geometry: clamping at both ends, degenerate segments, extremes.
    task automatic test_directed();
        localparam logic [31:0] MX = 32'h7FFF_FFFF;
        localparam logic [31:0] MN = 32'h8000_0000;
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] NONE = 32'hFFFF_0000;
        send_query(make_query({32'h0, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h0},
                              {32'h0, 32'h0, ONE}, 31'h0002_0000));
        send_query(make_query({32'h0, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h0},
                              {32'h0, 32'h0, 32'h0}, 31'h0));
        send_query(make_query({32'h0, 32'h0, ONE}, {32'h0, 32'h0, 32'h0000_5000},
                              {32'h0, 32'h0, ONE}, 31'h0001_0000));
        send_query(make_query({32'h0, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h000A_0000},
                              {32'h0, ONE, NONE}, 31'h0001_8000));
        send_query(make_query({32'h0, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h000A_0000},
                              {32'h0, NONE, 32'h000C_0000}, 31'h0001_0000));
        send_query(make_query({32'h0, 32'h0, 32'h0}, {ONE, ONE, 32'h0003_0000},
                              {32'h0, 32'h0002_0000, 32'h0001_4000}, 31'h0000_8000));
        send_query(make_query({32'h0, 32'h0, 32'h000A_0000}, {32'h0, 32'h0, NONE},
                              {ONE, 32'h0, 32'h0003_0000}, 31'h7FFF_FFFF));
        send_query(make_query({MN, MN, MN}, {MX, MX, MX}, {MX, MN, MX}, 31'h0));
        send_query(make_query({MX, MX, MX}, {MN, MN, MN}, {MN, MX, 32'h0}, 31'h7FFF_FFFF));
        send_query(make_query({MN, MN, MN}, {MN, MN, MN}, {MX, MX, MX}, 31'h0));
        send_query(make_query({MX, MN, MX}, {MN, MX, MN}, {32'h0, 32'h0, 32'h0}, 31'h1));
        send_query(make_query({MN, 32'h0, MX}, {MX, 32'h0, MN}, {MN, MX, MN}, 31'h4000_0000));
        send_query(make_query({32'hFFFF_FFFF, 32'h1, 32'h0}, {32'h1, 32'hFFFF_FFFF, 32'h0},
                              {32'h0, 32'h0, 32'h0}, 31'h0));
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            quiet_mode = ((n / 100) % 3 == 2);
            send_query(random_query());
        end
        quiet_mode = 0;
    endtask

    // Receiver holds off while requests keep coming until the input stalls.
    task automatic test_backpressure();
        quiet_mode = 1;
        rsp_hold_cycles = 400;
        for (int n = 0; n < 200; n++) send_query(random_query());
        quiet_mode = 0;
    endtask

    // Sender pauses until every outstanding result has come back.
    task automatic test_drain_pause();
        release_valid();
        wait_results_drained();
        for (int n = 0; n < 20; n++) send_query(random_query());
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.seg_start_x = '0;
        req_ch.seg_start_y = '0;
        req_ch.seg_start_z = '0;
        req_ch.seg_end_x = '0;
        req_ch.seg_end_y = '0;
        req_ch.seg_end_z = '0;
        req_ch.ball_center_x = '0;
        req_ch.ball_center_y = '0;
        req_ch.ball_center_z = '0;
        req_ch.ball_radius = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(310);
        test_backpressure();
        test_drain_pause();
        test_random(310);
        release_valid();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("segment_sphere_contact_core test passed");
        else
            $display("segment_sphere_contact_core test failed");
        $finish;
    end

endmodule

### filelist.f
hdl/ssc_pkg.sv
hdl/ssc_if.sv
hdl/ssc_proj.sv
hdl/ssc_sqrt.sv
hdl/ssc_norm.sv
hdl/segment_sphere_contact_core.sv
sim/segment_sphere_contact_core_tb.sv
